// ===== hw/rtl/pidl_pkg.sv =====
// ----------------------------------------------------------------------------
// pidl_pkg: shared types and constants for the positional list
// Beat formats, operation and status codes, and the per-cycle cell command.
// ----------------------------------------------------------------------------
package pidl_pkg;

  localparam int unsigned Capacity = 64;
  localparam int unsigned IdxW     = $clog2(Capacity);
  localparam int unsigned CntW     = $clog2(Capacity + 1);

  localparam int unsigned ModeW  = 3;
  localparam int unsigned PosW   = 7;
  localparam int unsigned DataW  = 32;
  localparam int unsigned StatW  = 2;
  localparam int unsigned LenW   = 7;

  localparam logic [ModeW-1:0] MODE_APPEND = 3'd0;
  localparam logic [ModeW-1:0] MODE_INSERT = 3'd1;
  localparam logic [ModeW-1:0] MODE_REMOVE = 3'd2;
  localparam logic [ModeW-1:0] MODE_POP    = 3'd3;
  localparam logic [ModeW-1:0] MODE_READ   = 3'd4;
  localparam logic [ModeW-1:0] MODE_WRITE  = 3'd5;

  localparam logic [StatW-1:0] ST_OK   = 2'd0;
  localparam logic [StatW-1:0] ST_BAD  = 2'd1;
  localparam logic [StatW-1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [ModeW-1:0]        mode;
    logic [PosW-1:0]         position;
    logic signed [DataW-1:0] value;
  } list_in_t;

  typedef struct packed {
    logic signed [DataW-1:0] read_value;
    logic [StatW-1:0]        status;
    logic [LenW-1:0]         length;
  } list_out_t;

  // Broadcast to every cell in the chain
  typedef struct packed {
    logic                    shift_up;
    logic                    shift_down;
    logic                    write_en;
    logic [IdxW-1:0]         pos;
    logic signed [DataW-1:0] value;
  } cell_cmd_t;

endpackage

// ===== hw/rtl/pidl_cell.sv =====
// ----------------------------------------------------------------------------
// pidl_cell: one list entry
// Holds one word; takes its lower neighbor's word on insert, its upper
// neighbor's word on removal, or the command value when addressed.
// ----------------------------------------------------------------------------
module pidl_cell (
  input  logic                             clk_i,
  input  logic [pidl_pkg::IdxW-1:0]        cell_idx_i,
  input  pidl_pkg::cell_cmd_t              cmd_i,
  input  logic signed [pidl_pkg::DataW-1:0] lower_i,
  input  logic signed [pidl_pkg::DataW-1:0] upper_i,
  output logic signed [pidl_pkg::DataW-1:0] data_o,
  output logic signed [pidl_pkg::DataW-1:0] hit_o
);
  import pidl_pkg::*;

  logic signed [DataW-1:0] data_q, data_d;
  logic                    at_pos, above_pos;

  assign at_pos    = (cell_idx_i == cmd_i.pos);
  assign above_pos = (cell_idx_i > cmd_i.pos);

  always_comb begin
    data_d = data_q;
    if (cmd_i.shift_up) begin
      if (above_pos) begin
        data_d = lower_i;
      end else if (at_pos) begin
        data_d = cmd_i.value;
      end
    end else if (cmd_i.shift_down) begin
      // close the gap: this entry and all above take their upper neighbor
      if (above_pos || at_pos) begin
        data_d = upper_i;
      end
    end else if (cmd_i.write_en && at_pos) begin
      data_d = cmd_i.value;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign hit_o  = at_pos ? data_q : '0;

endmodule

// ===== hw/rtl/pidl_ctrl.sv =====
// ----------------------------------------------------------------------------
// pidl_ctrl: request decode
// Checks the request against the current length, picks the cell command,
// the status and the new length.
// ----------------------------------------------------------------------------
module pidl_ctrl (
  input  logic                       fire_i,
  input  pidl_pkg::list_in_t         req_i,
  input  logic [pidl_pkg::CntW-1:0]  count_i,
  output pidl_pkg::cell_cmd_t        cmd_o,
  output logic                       rd_en_o,
  output logic [pidl_pkg::StatW-1:0] status_o,
  output logic [pidl_pkg::CntW-1:0]  count_o
);
  import pidl_pkg::*;

  localparam int unsigned CmpW = (PosW > CntW) ? PosW : CntW;

  logic [CmpW-1:0] pos_w, cnt_w;
  logic            full, empty, pos_lt, pos_le;
  logic [CntW-1:0] last_idx;

  assign pos_w    = CmpW'(req_i.position);
  assign cnt_w    = CmpW'(count_i);
  assign full     = (count_i == CntW'(Capacity));
  assign empty    = (count_i == '0);
  assign pos_lt   = (pos_w < cnt_w);
  assign pos_le   = (pos_w <= cnt_w);
  assign last_idx = count_i - CntW'(1);

  always_comb begin
    cmd_o.shift_up   = 1'b0;
    cmd_o.shift_down = 1'b0;
    cmd_o.write_en   = 1'b0;
    cmd_o.pos        = req_i.position[IdxW-1:0];
    cmd_o.value      = req_i.value;
    rd_en_o          = 1'b0;
    status_o         = ST_OK;
    count_o          = count_i;
    unique case (req_i.mode)
      MODE_APPEND: begin
        if (full) begin
          status_o = ST_FULL;
        end else begin
          cmd_o.write_en = fire_i;
          cmd_o.pos      = count_i[IdxW-1:0];
          count_o        = count_i + CntW'(1);
        end
      end
      MODE_INSERT: begin
        if (!pos_le) begin
          status_o = ST_BAD;
        end else if (full) begin
          status_o = ST_FULL;
        end else begin
          cmd_o.shift_up = fire_i;
          count_o        = count_i + CntW'(1);
        end
      end
      MODE_REMOVE: begin
        if (!pos_lt) begin
          status_o = ST_BAD;
        end else begin
          cmd_o.shift_down = fire_i;
          rd_en_o          = 1'b1;
          count_o          = last_idx;
        end
      end
      MODE_POP: begin
        cmd_o.pos = last_idx[IdxW-1:0];
        if (empty) begin
          status_o = ST_BAD;
        end else begin
          cmd_o.shift_down = fire_i;
          rd_en_o          = 1'b1;
          count_o          = last_idx;
        end
      end
      MODE_READ: begin
        if (!pos_lt) begin
          status_o = ST_BAD;
        end else begin
          rd_en_o = 1'b1;
        end
      end
      MODE_WRITE: begin
        if (!pos_lt) begin
          status_o = ST_BAD;
        end else begin
          cmd_o.write_en = fire_i;
        end
      end
      default: begin
        status_o = ST_BAD;
      end
    endcase
  end

endmodule

// ===== hw/rtl/positional_insert_delete_list.sv =====
// ----------------------------------------------------------------------------
// positional_insert_delete_list: ordered list with positional insert/remove
// A chain of entry cells that shift together on insert and removal.
// ----------------------------------------------------------------------------
// Usage:
//   Input beat (in_data_i): mode, position, value. Output beat (out_data_o):
//   read_value, status, length. Every request gives exactly one output beat.
//   Each request is decoded against the current length and applied to all
//   cells at once: on insert each cell above the position takes its
//   lower neighbor, on removal each cell at or above it takes its upper one.
//   A read picks the addressed cell through an OR tree across the chain.
//   The output beat is registered in the cycle after its request is taken;
//   one request per cycle is sustained while the receiver takes each beat,
//   limited by the single output register. While the receiver stalls, the
//   output beat holds and new requests wait until it is taken (in_ready_o
//   follows the output register). Reset empties the list (length zero) and
//   drops any pending output beat; entry contents are not cleared, since
//   only entries below the length are ever read.
// ----------------------------------------------------------------------------
module positional_insert_delete_list (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  pidl_pkg::list_in_t    in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output pidl_pkg::list_out_t   out_data_o
);
  import pidl_pkg::*;

  logic                    fire;
  logic [CntW-1:0]         count_q, count_d;
  logic                    out_valid_q;
  list_out_t               out_q;
  cell_cmd_t               cmd;
  logic                    rd_en;
  logic [StatW-1:0]        status;
  logic signed [DataW-1:0] cell_data [Capacity];
  logic signed [DataW-1:0] cell_hit  [Capacity];
  logic signed [DataW-1:0] rd_data;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign fire       = in_valid_i && in_ready_o;

  pidl_ctrl u_ctrl (
    .fire_i   (fire),
    .req_i    (in_data_i),
    .count_i  (count_q),
    .cmd_o    (cmd),
    .rd_en_o  (rd_en),
    .status_o (status),
    .count_o  (count_d)
  );

  for (genvar g = 0; g < Capacity; g++) begin : g_cell
    logic signed [DataW-1:0] lower, upper;
    if (g == 0) begin : g_first
      assign lower = '0;
    end else begin : g_mid_lo
      assign lower = cell_data[g-1];
    end
    if (g == Capacity - 1) begin : g_last
      assign upper = cell_data[g];
    end else begin : g_mid_hi
      assign upper = cell_data[g+1];
    end

    pidl_cell u_cell (
      .clk_i      (clk_i),
      .cell_idx_i (IdxW'(g)),
      .cmd_i      (cmd),
      .lower_i    (lower),
      .upper_i    (upper),
      .data_o     (cell_data[g]),
      .hit_o      (cell_hit[g])
    );
  end

  // only the addressed cell drives nonzero
  always_comb begin
    rd_data = '0;
    for (int k = 0; k < Capacity; k++) begin
      rd_data = rd_data | cell_hit[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q.read_value <= rd_en ? rd_data : '0;
      out_q.status     <= status;
      out_q.length     <= LenW'(count_d);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for positional_insert_delete_list
// Drives list requests over a valid/ready channel and checks each reply
// against a shadow copy of the list. A short directed table comes first, then
// random traffic in grow, mixed and shrink phases that fill and empty the
// list. Both channels idle at random, and the receiver stalls long once.
// ----------------------------------------------------------------------------
module testbench;
  import pidl_pkg::*;

  localparam logic [ModeW-1:0] MODE_UNUSED6 = 3'd6;
  localparam logic [ModeW-1:0] MODE_UNUSED7 = 3'd7;

  localparam int unsigned NumDirected  = 25;
  localparam int unsigned RandomItems  = 730;
  localparam int unsigned HoldCycles   = 60;
  localparam int unsigned IdleLimit    = 1000;
  localparam list_out_t   NoCheck      = '0;

  typedef enum logic [1:0] {GROW, MIX, SHRINK} phase_e;

  typedef struct packed {
    list_in_t  req;
    logic      fixed;
    list_out_t rsp;
  } row_t;

  logic      clk;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  list_in_t  in_data_i;
  logic      out_valid_o;
  logic      out_ready_i;
  list_out_t out_data_o;

  // Shadow of the list contents and length
  logic signed [DataW-1:0] shadow_list [Capacity];
  int unsigned             shadow_count;
  list_out_t               pending_results [$];

  row_t        directed_rows [NumDirected];
  int unsigned mismatches;
  int unsigned reqs_sent;
  int unsigned random_sent;
  int unsigned results_seen;
  int unsigned full_replies;
  int unsigned bad_replies;
  int unsigned idle_cycles;
  phase_e      phase;

  positional_insert_delete_list DUT (
    .clk_i      (clk),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Apply one request to the shadow list and return the reply it should give
  function automatic list_out_t predict_list_op(list_in_t req);
    list_out_t   rsp;
    int unsigned p;
    int unsigned i;
    rsp = '0;
    rsp.status = ST_OK;
    p = 32'(req.position);
    case (req.mode)
      MODE_APPEND: begin
        if (shadow_count >= Capacity) begin
          rsp.status = ST_FULL;
        end else begin
          shadow_list[shadow_count] = req.value;
          shadow_count++;
        end
      end
      MODE_INSERT: begin
        if (p > shadow_count) begin
          rsp.status = ST_BAD;
        end else if (shadow_count >= Capacity) begin
          rsp.status = ST_FULL;
        end else begin
          for (i = shadow_count; i > p; i--) shadow_list[i] = shadow_list[i-1];
          shadow_list[p] = req.value;
          shadow_count++;
        end
      end
      MODE_REMOVE: begin
        if (p >= shadow_count) begin
          rsp.status = ST_BAD;
        end else begin
          rsp.read_value = shadow_list[p];
          for (i = p; i + 1 < shadow_count; i++) shadow_list[i] = shadow_list[i+1];
          shadow_count--;
        end
      end
      MODE_POP: begin
        if (shadow_count == 0) begin
          rsp.status = ST_BAD;
        end else begin
          rsp.read_value = shadow_list[shadow_count-1];
          shadow_count--;
        end
      end
      MODE_READ: begin
        if (p >= shadow_count) rsp.status = ST_BAD;
        else rsp.read_value = shadow_list[p];
      end
      MODE_WRITE: begin
        if (p >= shadow_count) rsp.status = ST_BAD;
        else shadow_list[p] = req.value;
      end
      default: rsp.status = ST_BAD;
    endcase
    rsp.length = LenW'(shadow_count);
    return rsp;
  endfunction

  // Mostly back-to-back, sometimes a short gap, rarely a long one
  function automatic int unsigned gap_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_item(list_in_t req, logic use_fixed, list_out_t fixed_rsp);
    int unsigned gap;
    list_out_t   predicted;
    gap = gap_len();
    if (gap > 0) begin
      @(negedge clk);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    // hold the beat until it is taken
    do @(posedge clk); while (!in_ready_o);
    predicted = predict_list_op(req);
    if (use_fixed) predicted = fixed_rsp;
    if (predicted.status == ST_FULL) full_replies++;
    if (predicted.status == ST_BAD) bad_replies++;
    pending_results.push_back(predicted);
    reqs_sent++;
  endtask

  task automatic drive_random(phase_e ph);
    list_in_t    req;
    int unsigned cnt;
    int unsigned roll;
    cnt = shadow_count;
    case ($urandom_range(0, 7))
      0:       req.value = 32'sh7fffffff;
      1:       req.value = 32'sh80000000;
      2:       req.value = 32'shffffffff;
      3:       req.value = '0;
      default: req.value = $urandom;
    endcase
    req.position = PosW'($urandom_range(0, 127));
    roll = $urandom_range(0, 99);
    if (roll < 6) begin
      // noise: any mode, any position
      req.mode = ModeW'($urandom_range(0, 7));
    end else begin
      roll = $urandom_range(0, 99);
      case (ph)
        GROW: begin
          if (roll < 40)      req.mode = MODE_APPEND;
          else if (roll < 75) req.mode = MODE_INSERT;
          else if (roll < 85) req.mode = MODE_READ;
          else if (roll < 93) req.mode = MODE_WRITE;
          else if (roll < 97) req.mode = MODE_REMOVE;
          else                req.mode = MODE_POP;
        end
        SHRINK: begin
          if (roll < 40)      req.mode = MODE_REMOVE;
          else if (roll < 75) req.mode = MODE_POP;
          else if (roll < 85) req.mode = MODE_READ;
          else if (roll < 93) req.mode = MODE_WRITE;
          else if (roll < 97) req.mode = MODE_APPEND;
          else                req.mode = MODE_INSERT;
        end
        default: req.mode = ModeW'($urandom_range(MODE_APPEND, MODE_WRITE));
      endcase
      // keep most positions in range, favoring both ends
      if ($urandom_range(0, 9) != 0) begin
        roll = $urandom_range(0, 3);
        if (req.mode == MODE_INSERT) begin
          if (roll == 0)      req.position = '0;
          else if (roll == 1) req.position = PosW'(cnt);
          else                req.position = PosW'($urandom_range(0, cnt));
        end else if (req.mode inside {MODE_REMOVE, MODE_READ, MODE_WRITE} && cnt > 0) begin
          if (roll == 0)      req.position = '0;
          else if (roll == 1) req.position = PosW'(cnt - 1);
          else                req.position = PosW'($urandom_range(0, cnt - 1));
        end
      end
    end
    send_item(req, 1'b0, NoCheck);
    random_sent++;
  endtask

  // Check each output beat against the oldest pending reply
  always @(posedge clk) begin
    list_out_t exp_rsp;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected beat read_value %0d status %0d length %0d", $time,
                 out_data_o.read_value, out_data_o.status, out_data_o.length);
        mismatches++;
      end else begin
        exp_rsp = pending_results.pop_front();
        if (out_data_o.read_value !== exp_rsp.read_value) begin
          $display("%0t: read_value expected %0d got %0d", $time,
                   exp_rsp.read_value, out_data_o.read_value);
          mismatches++;
        end
        if (out_data_o.status !== exp_rsp.status) begin
          $display("%0t: status expected %0d got %0d", $time,
                   exp_rsp.status, out_data_o.status);
          mismatches++;
        end
        if (out_data_o.length !== exp_rsp.length) begin
          $display("%0t: length expected %0d got %0d", $time,
                   exp_rsp.length, out_data_o.length);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < IdleLimit) @(posedge clk);
    $display("Timeout: no beat moved for %0d cycles", IdleLimit);
    $display("FAIL");
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off so the input backs up
  initial begin
    int unsigned stall_left;
    logic        held;
    out_ready_i = 1'b0;
    stall_left  = 0;
    held        = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else if (!held && results_seen >= 40) begin
        out_ready_i <= 1'b0;
        stall_left = HoldCycles - 1;
        held = 1'b1;
      end else begin
        out_ready_i <= 1'b1;
        stall_left = gap_len();
      end
    end
  end

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_data_i    = '0;
    shadow_count = 0;
    mismatches   = 0;
    reqs_sent    = 0;
    random_sent  = 0;
    results_seen = 0;
    full_replies = 0;
    bad_replies  = 0;
    idle_cycles  = 0;

    directed_rows = '{
      '{'{MODE_POP,     7'd0,   32'sd0},           1'b1, '{32'sd0, ST_BAD, 7'd0}},
      '{'{MODE_READ,    7'd0,   32'sd0},           1'b1, '{32'sd0, ST_BAD, 7'd0}},
      '{'{MODE_REMOVE,  7'd0,   32'sd0},           1'b1, '{32'sd0, ST_BAD, 7'd0}},
      '{'{MODE_WRITE,   7'd0,   32'shffffffff},    1'b1, '{32'sd0, ST_BAD, 7'd0}},
      '{'{MODE_INSERT,  7'd1,   32'sd7},           1'b1, '{32'sd0, ST_BAD, 7'd0}},
      '{'{MODE_UNUSED6, 7'd0,   32'sd0},           1'b1, '{32'sd0, ST_BAD, 7'd0}},
      '{'{MODE_UNUSED7, 7'd127, 32'sh80000000},    1'b1, '{32'sd0, ST_BAD, 7'd0}},
      '{'{MODE_APPEND,  7'd0,   32'sh7fffffff},    1'b1, '{32'sd0, ST_OK,  7'd1}},
      '{'{MODE_APPEND,  7'd127, 32'sh80000000},    1'b1, '{32'sd0, ST_OK,  7'd2}},
      '{'{MODE_INSERT,  7'd0,   32'shffffffff},    1'b1, '{32'sd0, ST_OK,  7'd3}},
      '{'{MODE_INSERT,  7'd3,   32'sd5},           1'b1, '{32'sd0, ST_OK,  7'd4}},
      '{'{MODE_INSERT,  7'd2,   32'sh12345678},    1'b0, NoCheck},
      '{'{MODE_READ,    7'd4,   32'sd0},           1'b0, NoCheck},
      '{'{MODE_READ,    7'd0,   32'sd0},           1'b0, NoCheck},
      '{'{MODE_WRITE,   7'd1,   32'sd0},           1'b0, NoCheck},
      '{'{MODE_READ,    7'd1,   32'sd0},           1'b0, NoCheck},
      '{'{MODE_READ,    7'd5,   32'sd0},           1'b1, '{32'sd0, ST_BAD, 7'd5}},
      '{'{MODE_READ,    7'd127, 32'sd0},           1'b1, '{32'sd0, ST_BAD, 7'd5}},
      '{'{MODE_REMOVE,  7'd0,   32'sd0},           1'b0, NoCheck},
      '{'{MODE_REMOVE,  7'd3,   32'sd0},           1'b0, NoCheck},
      '{'{MODE_POP,     7'd64,  32'sd0},           1'b0, NoCheck},
      '{'{MODE_INSERT,  7'd64,  32'sd9},           1'b1, '{32'sd0, ST_BAD, 7'd2}},
      '{'{MODE_UNUSED6, 7'd64,  32'sh7fffffff},    1'b1, '{32'sd0, ST_BAD, 7'd2}},
      '{'{MODE_POP,     7'd0,   32'sd0},           1'b0, NoCheck},
      '{'{MODE_POP,     7'd0,   32'sd0},           1'b0, NoCheck}
    };

    repeat (8) @(negedge clk);
    rst_ni <= 1'b1;

    foreach (directed_rows[k])
      send_item(directed_rows[k].req, directed_rows[k].fixed, directed_rows[k].rsp);

    // Cycle through fill, churn and drain until the random budget is spent
    phase = GROW;
    while (random_sent < RandomItems) begin
      case (phase)
        GROW: begin
          while (shadow_count < Capacity && random_sent < RandomItems)
            drive_random(GROW);
          repeat (12) if (random_sent < RandomItems) drive_random(GROW);
          phase = MIX;
        end
        MIX: begin
          repeat (80) if (random_sent < RandomItems) drive_random(MIX);
          phase = SHRINK;
        end
        default: begin
          while (shadow_count > 0 && random_sent < RandomItems)
            drive_random(SHRINK);
          repeat (8) if (random_sent < RandomItems) drive_random(SHRINK);
          phase = GROW;
        end
      endcase
    end

    @(negedge clk);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);

    $display("Sent %0d requests (%0d directed), checked %0d replies", reqs_sent,
             NumDirected, results_seen);
    $display("Replies with list full: %0d, with bad position or empty: %0d",
             full_replies, bad_replies);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
